// File: hw/rtl/hfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC deframer package
// Shared widths, byte codes, result codes and the byte-wide CRC-CCITT update.
// ----------------------------------------------------------------------------
package hfd_pkg;

	localparam int MIN_FRAME_BYTES = 4;
	localparam int MAX_FRAME_BYTES = 4096;

	localparam int BYTE_COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int INDEX_W      = 12;
	localparam int CRC_W        = 16;
	localparam int MAX_LEN_W    = 13;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [7:0]       FLAG_BYTE = 8'h7E;
	localparam logic [7:0]       ESC_BYTE  = 8'h7D;
	localparam logic [7:0]       ESC_MASK  = 8'h20;
	localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;

	localparam logic [CRC_W-1:0]     CRC_INIT_RST      = 16'hFFFF;
	localparam logic [MAX_LEN_W-1:0] MAX_FRAME_LEN_RST = 13'd4096;

	// Register indexes, selected by paddr[2].
	localparam logic REG_CRC_INIT      = 1'b0;
	localparam logic REG_MAX_FRAME_LEN = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FTYPE_I = 2'd0,
		FTYPE_S = 2'd1,
		FTYPE_U = 2'd2
	} ftype_t;

	typedef struct packed {
		logic [CRC_W-1:0]     crc_init;
		logic [MAX_LEN_W-1:0] max_frame_len;
	} cfg_t;

	// One byte into the CRC, MSB first, eight bit steps.
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hfd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC deframer channels
// Valid/ready interfaces for the line byte input and the result output.
// ----------------------------------------------------------------------------
interface hfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte;
	logic [11:0] byte_index;
	logic [7:0]  frame_address;
	logic [7:0]  frame_control;
	logic [1:0]  frame_type;
	logic [11:0] info_len;

	modport source (output valid, output result_kind, output data_byte,
		output byte_index, output frame_address, output frame_control,
		output frame_type, output info_len, input ready);
	modport sink (input valid, input result_kind, input data_byte,
		input byte_index, input frame_address, input frame_control,
		input frame_type, input info_len, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/hfd_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC deframer configuration registers
// APB-style register file holding the CRC start value and the frame length limit.
// ----------------------------------------------------------------------------
module hfd_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [hfd_pkg::PDATA_W-1:0] pwdata,
	output logic      [hfd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output hfd_pkg::cfg_t                    cfg
);
	import hfd_pkg::*;

	logic [CRC_W-1:0]     crc_init_q;
	logic [MAX_LEN_W-1:0] max_frame_len_q;
	logic                 wr_en;

	// Registers sit on word addresses; the byte offset bits are ignored.
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_q      <= CRC_INIT_RST;
			max_frame_len_q <= MAX_FRAME_LEN_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_CRC_INIT:      crc_init_q      <= pwdata[CRC_W-1:0];
				REG_MAX_FRAME_LEN: max_frame_len_q <= pwdata[MAX_LEN_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CRC_INIT:      prdata = PDATA_W'(crc_init_q);
			REG_MAX_FRAME_LEN: prdata = PDATA_W'(max_frame_len_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.crc_init      = crc_init_q;
	assign cfg.max_frame_len = max_frame_len_q;

endmodule
`default_nettype wire

// File: hw/rtl/hdlc_frame_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC frame deframer
// Flag hunting, escape removal, CRC-CCITT check and frame-end reporting.
// ----------------------------------------------------------------------------
// Usage: raw line bytes arrive on the rx channel, one byte per transfer. Each
// byte is registered into an input stage, then processed by combinational
// logic (flag/escape decode, byte-wide CRC update, length check) whose result
// is captured in an output register. Line bytes that cause no result (escapes,
// bytes while hunting, flags that report no frame) still take one pass.
// Results leave on the res channel: a data byte with its index, a frame-good or
// frame-bad report with address, control, type and info length, or overflow.
// A byte passes through the input stage and then the output register before
// its result is valid. Throughput is one byte per cycle while the receiver
// does not stall; the limit is the CRC update between the input stage and the
// output register. If the receiver stalls, the output register holds its
// result and the input stage keeps one more byte; rx.ready drops only when
// both are full. The user must write configuration (crc_init, max_frame_len)
// over the APB port only while the block is idle; the block does not enforce
// this. Reset clears the pipeline, returns to flag hunting and loads crc_init
// = 0xFFFF and max_frame_len = 4096.
// ----------------------------------------------------------------------------
module hdlc_frame_deframer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	hfd_rx_if.sink                           rx,
	hfd_res_if.source                        res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [hfd_pkg::PDATA_W-1:0] pwdata,
	output logic      [hfd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import hfd_pkg::*;

	cfg_t cfg;

	hfd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// Frame state.
	logic                    in_frame_q;
	logic                    esc_q;
	logic [BYTE_COUNT_W-1:0] count_q;
	logic [CRC_W-1:0]        crc_q;
	logic [7:0]              held0_q;
	logic [7:0]              held1_q;
	logic [7:0]              addr_q;
	logic [7:0]              ctrl_q;

	// Output register.
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  data_q;
	logic [11:0] index_q;
	logic [7:0]  faddr_q;
	logic [7:0]  fctrl_q;
	ftype_t      ftype_q;
	logic [11:0] info_q;

	// Next result, worked out from the byte in the input stage.
	logic                    is_flag;
	logic                    is_esc;
	logic [7:0]              ubyte;
	logic [BYTE_COUNT_W-1:0] limit;
	logic                    ends_frame;
	logic                    overflow;
	logic                    res_valid_c;
	kind_t                   kind_c;
	ftype_t                  ftype_c;
	logic [BYTE_COUNT_W-1:0] info_c;

	// The input stage moves on when the output register is free or being emptied.
	assign adv      = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign is_flag = (byte_s1 == FLAG_BYTE);
	assign is_esc  = (byte_s1 == ESC_BYTE);
	assign ubyte   = esc_q ? (byte_s1 ^ ESC_MASK) : byte_s1;

	// The programmed limit is clipped to what the byte counter is sized for.
	assign limit = (cfg.max_frame_len > BYTE_COUNT_W'(MAX_FRAME_BYTES)) ?
		BYTE_COUNT_W'(MAX_FRAME_BYTES) : BYTE_COUNT_W'(cfg.max_frame_len);

	assign ends_frame = is_flag && in_frame_q && (count_q >= BYTE_COUNT_W'(MIN_FRAME_BYTES));
	assign overflow   = !is_flag && in_frame_q && !is_esc && (count_q >= limit);
	assign res_valid_c = ends_frame || (!is_flag && in_frame_q && !is_esc);

	// The received FCS is the last two bytes, high byte first.
	always_comb begin
		if (is_flag) begin
			kind_c = ({held0_q, held1_q} == crc_q) ? KIND_GOOD : KIND_BAD;
		end else if (overflow) begin
			kind_c = KIND_OVERFLOW;
		end else begin
			kind_c = KIND_DATA;
		end
	end

	always_comb begin
		if (!ctrl_q[0]) begin
			ftype_c = FTYPE_I;
		end else if (!ctrl_q[1]) begin
			ftype_c = FTYPE_S;
		end else begin
			ftype_c = FTYPE_U;
		end
	end

	assign info_c = (count_q >= BYTE_COUNT_W'(4)) ? (count_q - BYTE_COUNT_W'(4)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= '0;
			crc_q      <= CRC_INIT_RST;
			held0_q    <= '0;
			held1_q    <= '0;
			addr_q     <= '0;
			ctrl_q     <= '0;
		end else if (adv) begin
			if (is_flag) begin
				// A flag always opens the next frame, whether or not one ended.
				in_frame_q <= 1'b1;
				esc_q      <= 1'b0;
				count_q    <= '0;
				crc_q      <= cfg.crc_init;
				held0_q    <= '0;
				held1_q    <= '0;
			end else if (in_frame_q) begin
				if (is_esc) begin
					esc_q <= 1'b1;
				end else if (overflow) begin
					in_frame_q <= 1'b0;
					esc_q      <= 1'b0;
					count_q    <= '0;
				end else begin
					esc_q <= 1'b0;
					// Bytes enter the CRC two positions late, so the FCS never does.
					if (count_q >= BYTE_COUNT_W'(2)) begin
						crc_q <= crc_feed(crc_q, held0_q);
					end
					held0_q <= held1_q;
					held1_q <= ubyte;
					if (count_q == '0) begin
						addr_q <= ubyte;
					end
					if (count_q == BYTE_COUNT_W'(1)) begin
						ctrl_q <= ubyte;
					end
					count_q <= count_q + BYTE_COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid_c;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Fields that do not belong to a result kind are sent as zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q  <= kind_c;
			data_q  <= '0;
			index_q <= '0;
			faddr_q <= '0;
			fctrl_q <= '0;
			ftype_q <= FTYPE_I;
			info_q  <= '0;
			case (kind_c)
				KIND_DATA: begin
					data_q  <= ubyte;
					index_q <= count_q[INDEX_W-1:0];
				end
				KIND_GOOD, KIND_BAD: begin
					faddr_q <= addr_q;
					fctrl_q <= ctrl_q;
					ftype_q <= ftype_c;
					info_q  <= info_c[INDEX_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.result_kind   = kind_q;
	assign res.data_byte     = data_q;
	assign res.byte_index    = index_q;
	assign res.frame_address = faddr_q;
	assign res.frame_control = fctrl_q;
	assign res.frame_type    = ftype_q;
	assign res.info_len      = info_q;

`ifndef SYNTHESIS
	// An escape can only be pending inside a frame.
	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> in_frame_q)
		else $error("escape pending while hunting");

	// The byte counter never passes the largest frame it is sized for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= BYTE_COUNT_W'(MAX_FRAME_BYTES))
		else $error("byte counter beyond maximum frame size");

	// An overflow result always leaves the block hunting for a flag.
	a_ovf_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && overflow) |=> (!in_frame_q && out_valid_q))
		else $error("overflow did not return to hunting");

	// Input is held off only while both the input stage and output register are full.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && out_valid_q && !res.ready))
		else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// File: verif/hdlc_frame_deframer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC frame deframer testbench
// Feeds raw line bytes (flags, escapes, well-formed and broken frames) through
// the deframer under several CRC seeds and frame limits. A shadow model of the
// deframer predicts every result, which is checked field by field against the
// results that leave the block.
// ----------------------------------------------------------------------------
import hfd_pkg::*;

// One result as it leaves the block.
typedef struct packed {
	kind_t       kind;
	logic [7:0]  data;
	logic [11:0] idx;
	logic [7:0]  addr;
	logic [7:0]  ctrl;
	ftype_t      ftype;
	logic [11:0] info;
} frame_report_t;

// CRC-CCITT, one byte, MSB first, computed bit by bit on the feedback term.
function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
	logic fb;
	for (int i = 7; i >= 0; i--) begin
		fb = c[15] ^ d[i];
		c = {c[14:0], 1'b0};
		if (fb) begin
			c = c ^ CRC_POLY;
		end
	end
	return c;
endfunction

// Shadow copy of the deframer: its own state and registers, and the results it
// still owes in the order they must appear.
class deframe_tracker;
	logic [15:0]   crc_seed;
	logic [12:0]   len_limit;
	bit            in_frame;
	bit            esc_pending;
	int unsigned   count;
	logic [15:0]   crc_run;
	logic [7:0]    fcs_hold[2];
	logic [7:0]    hdr[2];
	frame_report_t reports_owed[$];
	int            errors;

	function new();
		crc_seed = CRC_INIT_RST;
		len_limit = MAX_FRAME_LEN_RST;
		in_frame = 0;
		esc_pending = 0;
		count = 0;
		crc_run = CRC_INIT_RST;
		fcs_hold[0] = '0;
		fcs_hold[1] = '0;
		hdr[0] = '0;
		hdr[1] = '0;
		errors = 0;
	endfunction

	function void take_line_byte(input logic [7:0] raw);
		frame_report_t r;
		logic [7:0] b;
		int unsigned cap;
		b = raw;
		r = '0;
		if (b == FLAG_BYTE) begin
			if (in_frame && count >= MIN_FRAME_BYTES) begin
				r.kind = ({fcs_hold[0], fcs_hold[1]} == crc_run) ? KIND_GOOD : KIND_BAD;
				r.addr = hdr[0];
				r.ctrl = hdr[1];
				if (!hdr[1][0]) begin
					r.ftype = FTYPE_I;
				end else if (!hdr[1][1]) begin
					r.ftype = FTYPE_S;
				end else begin
					r.ftype = FTYPE_U;
				end
				r.info = 12'(count - 4);
				reports_owed.push_back(r);
			end
			in_frame = 1;
			esc_pending = 0;
			count = 0;
			crc_run = crc_seed;
			fcs_hold[0] = '0;
			fcs_hold[1] = '0;
			return;
		end
		if (!in_frame) begin
			return;
		end
		if (b == ESC_BYTE) begin
			esc_pending = 1;
			return;
		end
		if (esc_pending) begin
			b = b ^ ESC_MASK;
			esc_pending = 0;
		end
		cap = (len_limit > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len_limit;
		if (count >= cap) begin
			r.kind = KIND_OVERFLOW;
			reports_owed.push_back(r);
			in_frame = 0;
			esc_pending = 0;
			count = 0;
			return;
		end
		if (count >= 2) begin
			crc_run = crc_ccitt_byte(crc_run, fcs_hold[0]);
		end
		fcs_hold[0] = fcs_hold[1];
		fcs_hold[1] = b;
		if (count == 0) begin
			hdr[0] = b;
		end else if (count == 1) begin
			hdr[1] = b;
		end
		r.kind = KIND_DATA;
		r.data = b;
		r.idx = 12'(count);
		count++;
		reports_owed.push_back(r);
	endfunction

	function void compare_field(input string name, input logic [15:0] want,
		input logic [15:0] seen);
		if (seen !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			errors++;
		end
	endfunction

	function void match_report(input frame_report_t seen);
		frame_report_t want;
		if (reports_owed.size() == 0) begin
			$error("result_kind: expected no result, got 0x%0h", seen.kind);
			errors++;
			return;
		end
		want = reports_owed.pop_front();
		compare_field("result_kind", want.kind, seen.kind);
		compare_field("data_byte", want.data, seen.data);
		compare_field("byte_index", want.idx, seen.idx);
		compare_field("frame_address", want.addr, seen.addr);
		compare_field("frame_control", want.ctrl, seen.ctrl);
		compare_field("frame_type", want.ftype, seen.ftype);
		compare_field("info_len", want.info, seen.info);
	endfunction
endclass

module hdlc_frame_deframer_unit_test;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	hfd_rx_if  rx_ch ();
	hfd_res_if res_ch ();

	deframe_tracker book;

	// Sender burst bookkeeping and the request for one long receiver hold-off.
	int burst_left = 0;
	bit long_hold_req = 1'b0;

	hdlc_frame_deframer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous run limit: about five hundred line bytes, each at worst waiting
	// out a sender gap and a receiver stall, plus the long hold-off and the
	// drains, then taken many times over.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Every transfer is observed at the rising edge. Results are checked before
	// the line byte of the same edge is noted, so a result can never be matched
	// against a prediction made in the same cycle.
	always @(posedge clk) begin : watch
		frame_report_t seen;
		if (res_ch.valid && res_ch.ready) begin
			seen.kind = kind_t'(res_ch.result_kind);
			seen.data = res_ch.data_byte;
			seen.idx = res_ch.byte_index;
			seen.addr = res_ch.frame_address;
			seen.ctrl = res_ch.frame_control;
			seen.ftype = ftype_t'(res_ch.frame_type);
			seen.info = res_ch.info_len;
			book.match_report(seen);
		end
		if (rx_ch.valid && rx_ch.ready) begin
			book.take_line_byte(rx_ch.rx_byte);
		end
	end

	// Receiver: ready steps through a 16-bit pattern that is redrawn when a random
	// span runs out. About a third of the patterns never stall. When the main
	// sequence asks for it, ready is held low for a long stretch so that the
	// output register and the input stage both fill and the line side stalls.
	initial begin : receiver
		logic [15:0] pattern;
		int pos;
		int span;
		int hold;
		res_ch.ready = 1'b0;
		pattern = '1;
		pos = 0;
		span = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold = 300;
				long_hold_req = 1'b0;
			end
			if (hold > 0) begin
				res_ch.ready = 1'b0;
				hold--;
			end else begin
				if (span == 0) begin
					span = $urandom_range(50, 300);
					pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				end
				span--;
				res_ch.ready = pattern[pos];
				pos = (pos + 1) % 16;
			end
		end
	end

	// One line byte over the rx channel. The sender works in bursts; between
	// bursts valid drops for a random gap, which is sometimes zero.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				rx_ch.valid = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
	endtask

	// Sends a frame body followed by its FCS (high byte first) and a closing
	// flag. Flag and escape bytes are always stuffed; other bytes are stuffed
	// now and then as well, as long as the stuffed form is not itself a flag
	// or an escape. A spoiled frame gets one FCS bit flipped.
	task automatic send_frame(input logic [7:0] body[$], input bit spoil);
		logic [15:0] fcs;
		logic [7:0] b;
		logic [7:0] alt;
		fcs = book.crc_seed;
		foreach (body[i]) begin
			fcs = crc_ccitt_byte(fcs, body[i]);
		end
		if (spoil) begin
			fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
		end
		body.push_back(fcs[15:8]);
		body.push_back(fcs[7:0]);
		foreach (body[i]) begin
			b = body[i];
			alt = b ^ ESC_MASK;
			if (b == FLAG_BYTE || b == ESC_BYTE || ($urandom_range(0, 15) == 0 &&
				alt != FLAG_BYTE && alt != ESC_BYTE)) begin
				send_byte(ESC_BYTE);
				send_byte(alt);
			end else begin
				send_byte(b);
			end
		end
		send_byte(FLAG_BYTE);
	endtask

	// A well-formed frame with random content, biased toward bytes that need
	// stuffing. A few are too short to report and some carry a bad FCS.
	task automatic send_random_frame(input int max_payload);
		logic [7:0] body[$];
		int len;
		if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(0, 1);
		end else begin
			len = $urandom_range(2, max_payload);
		end
		repeat (len) begin
			if ($urandom_range(0, 7) == 0) begin
				body.push_back($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
			end else begin
				body.push_back(8'($urandom));
			end
		end
		if (!book.in_frame || $urandom_range(0, 3) == 0) begin
			send_byte(FLAG_BYTE);
		end
		send_frame(body, $urandom_range(0, 4) == 0);
	endtask

	// Line noise and broken sequences.
	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			end
			1: begin
				send_byte(ESC_BYTE);
				send_byte(FLAG_BYTE);
			end
			2: begin
				send_byte(ESC_BYTE);
				send_byte(ESC_BYTE);
				send_byte(8'($urandom));
			end
			default: begin
				send_byte(FLAG_BYTE);
			end
		endcase
	endtask

	task automatic run_traffic(input int items, input int max_payload);
		for (int done = 0; done < items; ) begin
			if ($urandom_range(0, 4) == 0) begin
				send_noise();
				done += 3;
			end else begin
				send_random_frame(max_payload);
				done += max_payload / 2 + 3;
			end
		end
	endtask

	// The sender stops and waits until every owed result has arrived, then
	// lets the pipeline empty of bytes that cause no result.
	task automatic drain();
		rx_ch.valid = 1'b0;
		while (book.reports_owed.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_CRC_INIT) begin
			book.crc_seed = value[CRC_W-1:0];
		end else begin
			book.len_limit = value[MAX_LEN_W-1:0];
		end
	endtask

	task automatic configure(input logic [15:0] seed, input logic [12:0] limit);
		drain();
		reg_write(REG_CRC_INIT, PDATA_W'(seed));
		reg_write(REG_MAX_FRAME_LEN, PDATA_W'(limit));
		// Open a frame under the new seed before any traffic.
		send_byte(FLAG_BYTE);
	endtask

	initial begin : main
		logic [7:0] body[$];
		book = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, reset configuration. While hunting, data and escape
		// bytes are dropped; the first flag opens a frame, a second flag right
		// after it ends an empty frame without a result.
		send_byte(8'h00);
		send_byte(ESC_BYTE);
		send_byte(8'hFF);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		// U-frame whose content needs stuffing, good FCS.
		body = '{8'hFF, 8'h03, FLAG_BYTE, ESC_BYTE};
		send_frame(body, 1'b0);
		// S-frame with no information, bad FCS.
		body = '{8'h01, 8'h01};
		send_frame(body, 1'b1);
		// I-frame, good FCS.
		body = '{8'h00, 8'h10, 8'hA5};
		send_frame(body, 1'b0);
		// Escape after escape: the second escape only keeps the escape pending.
		send_byte(ESC_BYTE);
		send_byte(ESC_BYTE);
		send_byte(8'h5E);
		// Too short to report at the flag.
		send_byte(8'h12);
		send_byte(FLAG_BYTE);
		// A flag clears a pending escape, so the byte after it is taken as is.
		send_byte(8'h41);
		send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(8'h5D);
		send_byte(FLAG_BYTE);

		// Smallest legal limit with a zero seed: only header-plus-FCS frames fit.
		configure(16'h0000, 13'd4);
		run_traffic(80, 6);

		// Random seed and limit; the receiver holds off for a long stretch
		// while the sender keeps offering bytes.
		configure(16'($urandom), 13'($urandom_range(5, 64)));
		long_hold_req = 1'b1;
		run_traffic(100, 24);

		// Limit below the minimum frame: every long enough frame overflows.
		configure(16'h1D0F, 13'd3);
		run_traffic(60, 8);

		// Reset values written back explicitly.
		configure(16'hFFFF, 13'd4096);
		run_traffic(100, 40);

		// Largest register value, clamped to the frame size limit, with
		// ordinary traffic.
		configure(16'($urandom), 13'h1FFF);
		run_traffic(100, 16);

		drain();
		repeat (20) @(negedge clk);
		if (book.reports_owed.size() != 0) begin
			$error("result_kind: %0d expected results never arrived",
				book.reports_owed.size());
			book.errors++;
		end
		if (book.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/hfd_pkg.sv
hw/rtl/hfd_if.sv
hw/rtl/hfd_apb_regs.sv
hw/rtl/hdlc_frame_deframer_unit.sv
verif/hdlc_frame_deframer_unit_test.sv
